[design/clr_pkg.sv]
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the clipped line rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 2;
    localparam int COLOR_BITS   = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic emit;
        logic visible;
        logic last;
    } t_pix_flags;

endpackage

[design/clr_step.sv]
// ----------------------------------------------------------------------------
// clr_step
// Line setup and one Bresenham step: next line state and pixel flags.
// ----------------------------------------------------------------------------
module clr_step #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_op,
    input  logic signed [COORD_BITS-1:0]      i_start_x,
    input  logic signed [COORD_BITS-1:0]      i_start_y,
    input  logic signed [COORD_BITS-1:0]      i_end_x,
    input  logic signed [COORD_BITS-1:0]      i_end_y,
    input  logic [clr_pkg::CFG_BITS-1:0]      i_width,
    input  logic [clr_pkg::CFG_BITS-1:0]      i_height,
    input  logic                              i_busy,
    input  logic signed [COORD_BITS-1:0]      i_cur_x,
    input  logic signed [COORD_BITS-1:0]      i_cur_y,
    input  logic signed [COORD_BITS-1:0]      i_tgt_x,
    input  logic signed [COORD_BITS-1:0]      i_tgt_y,
    input  logic [COORD_BITS:0]               i_dx,
    input  logic [COORD_BITS:0]               i_dy,
    input  logic                              i_dir_xn,
    input  logic                              i_dir_yn,
    input  logic signed [COORD_BITS+1:0]      i_err,
    output logic                              o_busy,
    output logic signed [COORD_BITS-1:0]      o_cur_x,
    output logic signed [COORD_BITS-1:0]      o_cur_y,
    output logic signed [COORD_BITS-1:0]      o_tgt_x,
    output logic signed [COORD_BITS-1:0]      o_tgt_y,
    output logic [COORD_BITS:0]               o_dx,
    output logic [COORD_BITS:0]               o_dy,
    output logic                              o_dir_xn,
    output logic                              o_dir_yn,
    output logic signed [COORD_BITS+1:0]      o_err,
    output clr_pkg::t_pix_flags               o_flags
);

    localparam int DW  = COORD_BITS + 1;
    localparam int EW  = COORD_BITS + 2;
    localparam int E2W = COORD_BITS + 3;
    localparam int CMP_BITS = (COORD_BITS > clr_pkg::CFG_BITS) ? COORD_BITS
                                                                : clr_pkg::CFG_BITS;

    logic signed [DW-1:0]  diff_x, diff_y;
    logic [DW-1:0]         abs_x, abs_y;
    logic signed [EW-1:0]  err_start;
    logic                  at_end, vis_x, vis_y;
    logic signed [E2W-1:0] e2, dx_e, dy_e, dx_add, dy_sub, err_sum;
    logic                  step_x, step_y;
    logic [COORD_BITS-1:0] inc_x, inc_y;

    assign diff_x    = DW'(i_end_x) - DW'(i_start_x);
    assign diff_y    = DW'(i_end_y) - DW'(i_start_y);
    assign abs_x     = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    assign abs_y     = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    assign err_start = $signed({1'b0, abs_x}) - $signed({1'b0, abs_y});

    assign at_end = (i_cur_x == i_tgt_x) && (i_cur_y == i_tgt_y);
    assign vis_x  = !i_cur_x[COORD_BITS-1] &&
                    (CMP_BITS'($unsigned(i_cur_x)) < CMP_BITS'(i_width));
    assign vis_y  = !i_cur_y[COORD_BITS-1] &&
                    (CMP_BITS'($unsigned(i_cur_y)) < CMP_BITS'(i_height));

    assign e2      = $signed({i_err, 1'b0});
    assign dx_e    = E2W'($signed({1'b0, i_dx}));
    assign dy_e    = E2W'($signed({1'b0, i_dy}));
    assign step_x  = e2 > -dy_e;
    assign step_y  = e2 < dx_e;
    assign dy_sub  = step_x ? dy_e : E2W'(0);
    assign dx_add  = step_y ? dx_e : E2W'(0);
    assign err_sum = E2W'(i_err) - dy_sub + dx_add;

    assign inc_x = i_dir_xn ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    assign inc_y = i_dir_yn ? {COORD_BITS{1'b1}} : COORD_BITS'(1);

    always_comb begin
        o_busy   = i_busy;
        o_cur_x  = i_cur_x;
        o_cur_y  = i_cur_y;
        o_tgt_x  = i_tgt_x;
        o_tgt_y  = i_tgt_y;
        o_dx     = i_dx;
        o_dy     = i_dy;
        o_dir_xn = i_dir_xn;
        o_dir_yn = i_dir_yn;
        o_err    = i_err;
        o_flags.emit    = (i_op == clr_pkg::OP_STEP) && i_busy;
        o_flags.visible = vis_x && vis_y;
        o_flags.last    = at_end;
        if (i_op == clr_pkg::OP_START) begin
            o_busy   = 1'b1;
            o_cur_x  = i_start_x;
            o_cur_y  = i_start_y;
            o_tgt_x  = i_end_x;
            o_tgt_y  = i_end_y;
            o_dx     = abs_x;
            o_dy     = abs_y;
            o_dir_xn = !(i_start_x < i_end_x);
            o_dir_yn = !(i_start_y < i_end_y);
            o_err    = err_start;
        end else if (i_busy) begin
            if (at_end) begin
                o_busy = 1'b0;
            end else begin
                o_err = err_sum[EW-1:0];
                if (step_x) begin
                    o_cur_x = i_cur_x + inc_x;
                end
                if (step_y) begin
                    o_cur_y = i_cur_y + inc_y;
                end
            end
        end
    end

endmodule

[design/clipped_line_raster.sv]
// Throughput: one request per cycle while o_in_stall is low; line setup and each step are
// a single add-compare pass. A step request's pixel is registered in the output register;
// a one-entry skid register holds it instead while the output is stalled.
// Reset (i_rst_n low, synchronous): idle, output and skid empty, screen 640 x 480.
// ----------------------------------------------------------------------------
// clipped_line_raster
// Bresenham line rasterizer with screen clipping flags.
// ----------------------------------------------------------------------------
module clipped_line_raster #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    input  logic [clr_pkg::COLOR_BITS-1:0]      i_line_color,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [COORD_BITS-1:0]        o_pixel_x,
    output logic signed [COORD_BITS-1:0]        o_pixel_y,
    output logic [clr_pkg::COLOR_BITS-1:0]      o_pixel_color,
    output logic                                o_visible,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [clr_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [clr_pkg::CFG_BITS-1:0]        i_cfg_data
);

    logic [clr_pkg::CFG_BITS-1:0]   r_width, r_height;
    logic                           r_busy;
    logic signed [COORD_BITS-1:0]   r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [COORD_BITS:0]            r_dx, r_dy;
    logic                           r_dir_xn, r_dir_yn;
    logic signed [COORD_BITS+1:0]   r_err;
    logic [clr_pkg::COLOR_BITS-1:0] r_color;

    logic                           n_busy;
    logic signed [COORD_BITS-1:0]   n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic [COORD_BITS:0]            n_dx, n_dy;
    logic                           n_dir_xn, n_dir_yn;
    logic signed [COORD_BITS+1:0]   n_err;
    clr_pkg::t_pix_flags            flags;

    logic                           r_out_valid;
    logic signed [COORD_BITS-1:0]   r_out_x, r_out_y;
    logic [clr_pkg::COLOR_BITS-1:0] r_out_color;
    logic                           r_out_vis, r_out_last;

    logic                           r_skid_valid;
    logic signed [COORD_BITS-1:0]   r_skid_x, r_skid_y;
    logic [clr_pkg::COLOR_BITS-1:0] r_skid_color;
    logic                           r_skid_vis, r_skid_last;

    logic                           in_acc, produce, out_free;

    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !r_skid_valid;
    assign produce     = in_acc && flags.emit;
    assign out_free    = !r_out_valid || !i_out_stall;

    clr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_op      (i_op),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_busy    (r_busy),
        .i_cur_x   (r_cur_x),
        .i_cur_y   (r_cur_y),
        .i_tgt_x   (r_tgt_x),
        .i_tgt_y   (r_tgt_y),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .i_dir_xn  (r_dir_xn),
        .i_dir_yn  (r_dir_yn),
        .i_err     (r_err),
        .o_busy    (n_busy),
        .o_cur_x   (n_cur_x),
        .o_cur_y   (n_cur_y),
        .o_tgt_x   (n_tgt_x),
        .o_tgt_y   (n_tgt_y),
        .o_dx      (n_dx),
        .o_dy      (n_dy),
        .o_dir_xn  (n_dir_xn),
        .o_dir_yn  (n_dir_yn),
        .o_err     (n_err),
        .o_flags   (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clr_pkg::WIDTH_RESET;
            r_height <= clr_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clr_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                clr_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_dir_xn <= 1'b0;
            r_dir_yn <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
        end else if (in_acc) begin
            r_busy   <= n_busy;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_tgt_x  <= n_tgt_x;
            r_tgt_y  <= n_tgt_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_dir_xn <= n_dir_xn;
            r_dir_yn <= n_dir_yn;
            r_err    <= n_err;
            if (i_op == clr_pkg::OP_START) begin
                r_color <= i_line_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_x     <= r_skid_x;
                r_out_y     <= r_skid_y;
                r_out_color <= r_skid_color;
                r_out_vis   <= r_skid_vis;
                r_out_last  <= r_skid_last;
            end else if (produce) begin
                r_out_x     <= r_cur_x;
                r_out_y     <= r_cur_y;
                r_out_color <= r_color;
                r_out_vis   <= flags.visible;
                r_out_last  <= flags.last;
            end
        end else if (produce) begin
            r_skid_x     <= r_cur_x;
            r_skid_y     <= r_cur_y;
            r_skid_color <= r_color;
            r_skid_vis   <= flags.visible;
            r_skid_last  <= flags.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_visible     = r_out_vis;
    assign o_last        = r_out_last;

endmodule

[design/clr_check.sv]
// ----------------------------------------------------------------------------
// clr_check
// Port-level checks of the clipped line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module clr_check #(
    parameter int COORD_BITS = 12
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_op,
    input logic signed [COORD_BITS-1:0]        i_start_x,
    input logic signed [COORD_BITS-1:0]        i_start_y,
    input logic [clr_pkg::COLOR_BITS-1:0]      i_line_color,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [COORD_BITS-1:0]        o_pixel_x,
    input logic signed [COORD_BITS-1:0]        o_pixel_y,
    input logic [clr_pkg::COLOR_BITS-1:0]      o_pixel_color
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x) &&
            $stable(o_pixel_y) && $stable(o_pixel_color))
        else $error("stalled pixel changed");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !i_out_stall |=> !o_in_stall)
        else $error("input stall held with output free");

    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_op == clr_pkg::OP_START) && (!o_out_valid || !i_out_stall)
            |=> !o_out_valid)
        else $error("start request produced a pixel");

    a_first_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_op == clr_pkg::OP_STEP) && (!o_out_valid || !i_out_stall) &&
            $past(i_rst_n) && $past(in_acc) && ($past(i_op) == clr_pkg::OP_START)
            |=> o_out_valid && (o_pixel_x == $past(i_start_x, 2)) &&
                (o_pixel_y == $past(i_start_y, 2)) &&
                (o_pixel_color == $past(i_line_color, 2)))
        else $error("first pixel differs from start point");

endmodule

bind clipped_line_raster clr_check #(
    .COORD_BITS (COORD_BITS)
) u_clr_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_op          (i_op),
    .i_start_x     (i_start_x),
    .i_start_y     (i_start_y),
    .i_line_color  (i_line_color),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_pixel_color (o_pixel_color)
);
